/* rtl/lpr_pkg.sv */
// shared constants, types and conversions for the lru page replacement block
package lpr_pkg;

   localparam int FRAMES         = 16;
   localparam int PAGE_BITS      = 16;
   localparam int IDX_BITS       = (FRAMES > 1) ? $clog2(FRAMES) : 1;
   localparam int OCC_BITS       = $clog2(FRAMES + 1);
   localparam int LIMIT_BITS     = 5;
   localparam int COUNT_BITS     = 32;
   localparam int PAGE_PORT_BITS = 16;
   localparam int SLOT_PORT_BITS = 4;
   localparam int LIMIT_RESET    = 16;

   typedef logic [PAGE_BITS-1:0]      page_type;
   typedef logic [IDX_BITS-1:0]       idx_type;
   typedef logic [OCC_BITS-1:0]       occ_type;
   typedef logic [LIMIT_BITS-1:0]     limit_type;
   typedef logic [COUNT_BITS-1:0]     count_type;
   typedef logic [PAGE_PORT_BITS-1:0] page_port_type;
   typedef logic [SLOT_PORT_BITS-1:0] slot_port_type;

   // one recency position: the page and the slot it lives in
   typedef struct packed {
      page_type page;
      idx_type  slot;
   } entry_type;

   typedef struct packed {
      logic live;
      logic shift;
      logic load;
   } cell_ctrl_type;

   function automatic page_type port_to_page(page_port_type p);
      logic [63:0] w;
      w = 64'(p);
      return w[PAGE_BITS-1:0];
   endfunction

   function automatic page_port_type page_to_port(page_type p);
      logic [63:0] w;
      w = 64'(p);
      return w[PAGE_PORT_BITS-1:0];
   endfunction

   function automatic slot_port_type idx_to_slot(idx_type s);
      logic [63:0] w;
      w = 64'(s);
      return w[SLOT_PORT_BITS-1:0];
   endfunction

endpackage

/* rtl/lru_page_replacement.sv */
// lru page replacement top level: chain of recency cells, control and result register
//
//   channel | ports                        | direction | handshake
//   req     | req_page, req_first          | in        | req_valid / req_ready
//   rsp     | rsp_fault .. rsp_fault_total | out       | rsp_valid / rsp_ready
//   csr     | csr_wr_data                  | in        | csr_wr_en, no wait
//
// one word is taken per cycle while req_ready is high; its result is in the output register in the cycle after.
// all cells compare in parallel; on a hit the cells from the hit position up shift, on an eviction all live cells do.
// req_ready is high while the output register is empty or being drained.
// synchronous reset empties the table, clears the fault count and sets the limit to 16.
// cell contents are not reset; only positions below the occupancy are looked at.
module lru_page_replacement (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  lpr_pkg::page_port_type  req_page,
   input  logic                    req_first,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic                    rsp_fault,
   output lpr_pkg::slot_port_type  rsp_slot,
   output logic                    rsp_evicted_valid,
   output lpr_pkg::page_port_type  rsp_evicted_page,
   output lpr_pkg::count_type      rsp_fault_total,
   input  logic                    csr_wr_en,
   input  lpr_pkg::limit_type      csr_wr_data
);
   import lpr_pkg::*;

   limit_type     limit_ff;
   occ_type       occ_ff, occ_in;
   count_type     count_ff, count_in;
   logic          rsp_valid_ff;
   logic          fault_ff;
   slot_port_type slot_ff;
   logic          ev_valid_ff;
   page_port_type ev_page_ff;

   page_type      lookup_page;
   occ_type       occ_eff;
   occ_type       lim_eff;
   count_type     count_base;
   logic          accept;
   logic          hit, append, evict;
   idx_type       hit_pos, hit_slot, rot_start;
   entry_type     new_entry;
   entry_type     cell_entry [FRAMES];
   entry_type     cell_next  [FRAMES];
   cell_ctrl_type cell_ctrl  [FRAMES];
   logic [FRAMES-1:0] match;

   assign req_ready   = !rsp_valid_ff || rsp_ready;
   assign accept      = req_valid && req_ready;
   assign lookup_page = port_to_page(req_page);
   assign occ_eff     = req_first ? '0 : occ_ff;

   always_comb begin
      if (limit_ff == '0) begin
         lim_eff = occ_type'(1);
      end else if (32'(limit_ff) > FRAMES) begin
         lim_eff = occ_type'(FRAMES);
      end else begin
         lim_eff = occ_type'(limit_ff);
      end
   end

   // matches are one-hot since a page is never resident twice
   always_comb begin
      hit_pos  = '0;
      hit_slot = '0;
      for (int i = 0; i < FRAMES; i++) begin
         if (match[i]) begin
            hit_pos  = hit_pos | IDX_BITS'(i);
            hit_slot = hit_slot | cell_entry[i].slot;
         end
      end
   end

   assign hit       = |match;
   assign append    = !hit && (occ_eff < lim_eff);
   assign evict     = !hit && !append;
   assign rot_start = hit ? hit_pos : '0;

   always_comb begin
      new_entry.page = lookup_page;
      priority if (hit) begin
         new_entry.slot = hit_slot;
      end else if (append) begin
         new_entry.slot = IDX_BITS'(occ_eff);
      end else begin
         new_entry.slot = cell_entry[0].slot;
      end
   end

   genvar g;
   generate
      for (g = 0; g < FRAMES; g++) begin : g_cell
         if (g + 1 < FRAMES) begin : g_mid
            assign cell_next[g] = cell_entry[g+1];
         end else begin : g_last
            assign cell_next[g] = cell_entry[g];
         end

         always_comb begin
            cell_ctrl[g].live  = OCC_BITS'(g) < occ_eff;
            cell_ctrl[g].shift = accept && !append && (IDX_BITS'(g) >= rot_start)
                                 && (OCC_BITS'(g + 1) < occ_eff);
            cell_ctrl[g].load  = accept && (append ? (OCC_BITS'(g) == occ_eff)
                                                   : (OCC_BITS'(g + 1) == occ_eff));
         end

         lpr_cell u_cell (
            .clock          (clock),
            .ctrl           (cell_ctrl[g]),
            .lookup_page    (lookup_page),
            .neighbor_entry (cell_next[g]),
            .new_entry      (new_entry),
            .entry          (cell_entry[g]),
            .match          (match[g])
         );
      end
   endgenerate

   always_comb begin
      count_base = req_first ? '0 : count_ff;
      count_in   = count_base;
      if (!hit && (count_base != '1)) begin
         count_in = count_base + 1'b1;
      end
      occ_in = append ? occ_eff + 1'b1 : occ_eff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff     <= LIMIT_BITS'(LIMIT_RESET);
         occ_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            limit_ff <= csr_wr_data;
         end
         if (accept) begin
            occ_ff       <= occ_in;
            count_ff     <= count_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         fault_ff    <= !hit;
         slot_ff     <= idx_to_slot(new_entry.slot);
         ev_valid_ff <= evict;
         ev_page_ff  <= evict ? page_to_port(cell_entry[0].page) : '0;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_fault         = fault_ff;
   assign rsp_slot          = slot_ff;
   assign rsp_evicted_valid = ev_valid_ff;
   assign rsp_evicted_page  = ev_page_ff;
   assign rsp_fault_total   = count_ff;

   // at most one live cell holds the looked-up page
   assert property (@(posedge clock) disable iff (reset) $onehot0(match))
      else $error("more than one cell matched the page");

   // a hit never reports an eviction
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !fault_ff |-> !ev_valid_ff && (ev_page_ff == '0))
      else $error("hit reported an evicted page");

   // a miss into a free slot grows the occupancy by one
   assert property (@(posedge clock) disable iff (reset)
      accept && append |=> occ_ff == $past(occ_eff) + 1'b1)
      else $error("occupancy did not grow on fill");

   // occupancy never passes the number of cells
   assert property (@(posedge clock) disable iff (reset)
      32'(occ_ff) <= FRAMES)
      else $error("occupancy beyond frame count");

endmodule

/* rtl/lpr_cell.sv */
// one recency position of the lru stack: holds an entry, compares it, takes from its neighbor
module lpr_cell (
   input  logic                  clock,
   input  lpr_pkg::cell_ctrl_type ctrl,
   input  lpr_pkg::page_type     lookup_page,
   input  lpr_pkg::entry_type    neighbor_entry,
   input  lpr_pkg::entry_type    new_entry,
   output lpr_pkg::entry_type    entry,
   output logic                  match
);
   import lpr_pkg::*;

   entry_type entry_ff;
   entry_type entry_in;

   assign entry = entry_ff;
   assign match = ctrl.live && (entry_ff.page == lookup_page);

   always_comb begin
      priority if (ctrl.load) begin
         entry_in = new_entry;
      end else if (ctrl.shift) begin
         entry_in = neighbor_entry;
      end else begin
         entry_in = entry_ff;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

/* test/lru_page_replacement_tb.sv */
// self-checking testbench for the lru page replacement block
`timescale 1ns / 100ps

module lru_page_replacement_tb;
   import lpr_pkg::*;

   typedef struct packed {
      page_port_type page;
      logic          first;
   } page_ref_type;

   typedef struct packed {
      logic          fault;
      slot_port_type slot;
      logic          evicted_valid;
      page_port_type evicted_page;
      count_type     fault_total;
   } ref_outcome_type;

   logic          clock;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_ready;
   page_port_type req_page = '0;
   logic          req_first = 1'b0;
   logic          rsp_valid;
   logic          rsp_ready = 1'b0;
   logic          rsp_fault;
   slot_port_type rsp_slot;
   logic          rsp_evicted_valid;
   page_port_type rsp_evicted_page;
   count_type     rsp_fault_total;
   logic          csr_wr_en = 1'b0;
   limit_type     csr_wr_data = '0;

   lru_page_replacement uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_page(req_page),
      .req_first(req_first),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_fault(rsp_fault),
      .rsp_slot(rsp_slot),
      .rsp_evicted_valid(rsp_evicted_valid),
      .rsp_evicted_page(rsp_evicted_page),
      .rsp_fault_total(rsp_fault_total),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   page_ref_type    pending_refs[$];
   ref_outcome_type predicted_outcomes[$];
   logic            holding = 1'b0;
   logic            no_gaps = 1'b0;
   int              mismatches = 0;

   // predictor state
   limit_type     frame_limit = limit_type'(LIMIT_RESET);
   page_port_type resident_page[FRAMES];
   int            recency_slot[FRAMES];
   int            frames_filled = 0;
   count_type     faults_seen = '0;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("tb: failure");
      $finish;
   end

   function automatic int clamp_limit(limit_type v);
      if (v == 0) return 1;
      if (v > FRAMES) return FRAMES;
      return int'(v);
   endfunction

   // drop recency position pos and put slot s at the most recent end
   function automatic void promote(int pos, int s);
      for (int i = pos; i < frames_filled - 1; i++)
         recency_slot[i] = recency_slot[i + 1];
      recency_slot[frames_filled - 1] = s;
   endfunction

   function automatic ref_outcome_type lru_reference(page_port_type pg, logic mark);
      ref_outcome_type r;
      logic hit;
      int s;
      int pos;
      r = '0;
      hit = 1'b0;
      s = 0;
      pos = 0;
      if (mark) begin
         frames_filled = 0;
         faults_seen = '0;
      end
      for (int i = 0; i < frames_filled; i++)
         if (!hit && resident_page[i] == pg) begin
            hit = 1'b1;
            s = i;
         end
      if (hit) begin
         for (int i = 0; i < frames_filled; i++)
            if (recency_slot[i] == s) pos = i;
         promote(pos, s);
      end else begin
         if (frames_filled < clamp_limit(frame_limit)) begin
            s = frames_filled;
            resident_page[s] = pg;
            recency_slot[s] = s;
            frames_filled++;
         end else begin
            // table full (or limit lowered below it): replace least recent
            s = recency_slot[0];
            r.evicted_valid = 1'b1;
            r.evicted_page = resident_page[s];
            resident_page[s] = pg;
            promote(0, s);
         end
         if (faults_seen != '1) faults_seen++;
      end
      r.fault = !hit;
      r.slot = slot_port_type'(s);
      r.fault_total = faults_seen;
      return r;
   endfunction

   task automatic report_mismatch(string what);
      mismatches++;
      if (mismatches <= 100) $display("mismatch at %0t: %s", $time, what);
   endtask

   task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
   endtask

   // driver
   always @(posedge clock) begin : drive
      page_ref_type    nxt;
      ref_outcome_type pred;
      if (reset) begin
         req_valid <= 1'b0;
         holding = 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            pred = lru_reference(req_page, req_first);
            predicted_outcomes = {predicted_outcomes, pred};
            holding = 1'b0;
         end
         if (!holding) begin
            if (pending_refs.size() > 0 && (no_gaps || $urandom_range(99) >= 20)) begin
               nxt = pending_refs.pop_front();
               req_page <= nxt.page;
               req_first <= nxt.first;
               req_valid <= 1'b1;
               holding = 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin : watch
      ref_outcome_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (predicted_outcomes.size() == 0) begin
               report_mismatch("result word with nothing expected");
            end else begin
               want = predicted_outcomes.pop_front();
               check_field("fault", rsp_fault, want.fault);
               check_field("slot", rsp_slot, want.slot);
               check_field("evicted_valid", rsp_evicted_valid, want.evicted_valid);
               check_field("evicted_page", rsp_evicted_page, want.evicted_page);
               check_field("fault_total", rsp_fault_total, want.fault_total);
            end
         end
         rsp_ready <= no_gaps || ($urandom_range(99) >= 20);
      end
   end

   task automatic push_ref(page_port_type pg, logic mark);
      page_ref_type item;
      item.page = pg;
      item.first = mark;
      pending_refs = {pending_refs, item};
   endtask

   task automatic wait_idle();
      while (pending_refs.size() != 0 || holding || predicted_outcomes.size() != 0)
         @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic set_frame_limit(limit_type v);
      wait_idle();
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      frame_limit = v;
   endtask

   // references drawn mostly from a small working set around the frame limit
   task automatic push_sequence(int n, int span, logic mark);
      page_port_type pool[24];
      int pick;
      for (int i = 0; i < span; i++) pool[i] = page_port_type'($urandom);
      for (int i = 0; i < n; i++) begin
         pick = $urandom_range(99);
         if (pick < 88)
            push_ref(pool[$urandom_range(span - 1)], (i == 0) ? mark : 1'b0);
         else if (pick < 97)
            push_ref(page_port_type'($urandom), (i == 0) ? mark : 1'b0);
         else
            push_ref(pool[$urandom_range(span - 1)], 1'b1);
      end
   endtask

   task automatic run_phase(limit_type v, int n_items);
      int done;
      int len;
      int span;
      logic mark;
      set_frame_limit(v);
      done = 0;
      mark = 1'b0;  // first run continues the table left by the previous setting
      while (done < n_items) begin
         len = $urandom_range(60, 5);
         if (len > n_items - done) len = n_items - done;
         span = clamp_limit(v) + $urandom_range(6) - 3;
         if (span < 1) span = 1;
         push_sequence(len, span, mark);
         done += len;
         mark = 1'b1;
      end
      wait_idle();
   endtask

   initial begin : stimulus
      limit_type settings[19];
      settings = '{5'd31, 5'd17, 5'd1, 5'd5, 5'd16, 5'd2, 5'd8, 5'd3, 5'd12, 5'd4,
                   5'd16, 5'd7, 5'd10, 5'd6, 5'd15, 5'd14, 5'd9, 5'd11, 5'd13};
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // no first mark right after reset, extremes of the page field
      push_ref(16'h0000, 1'b0);
      push_ref(16'hFFFF, 1'b0);
      push_ref(16'h0000, 1'b0);
      push_ref(16'hAAAA, 1'b0);
      push_ref(16'h5555, 1'b0);
      push_ref(16'hFFFF, 1'b0);
      push_ref(16'h0000, 1'b1);
      // fill all sixteen slots, the last one evicts page zero
      for (int i = 1; i <= 16; i++) push_ref(page_port_type'(i), 1'b0);
      wait_idle();

      // limit of zero behaves as one frame
      set_frame_limit(5'd0);
      push_ref(16'h1234, 1'b1);
      push_ref(16'h4321, 1'b0);
      push_ref(16'h4321, 1'b0);
      push_ref(16'h1234, 1'b0);
      wait_idle();

      foreach (settings[k]) begin
         no_gaps = (k == 6);
         run_phase(settings[k], 95);
      end
      no_gaps = 1'b0;

      wait_idle();
      repeat (8) @(posedge clock);
      if (mismatches == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
